@@ sv/fpcr_pkg.sv @@
// Package for the fixed-point cube root block.
// Holds defaults, register codes, microcode types and the microcode table.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package fpcr_pkg;

  localparam int FRAC_BITS_DEF  = 12;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ITER_W     = 5;
  localparam logic [ITER_W-1:0] ITER_RESET = 5'd20;

  // Register index, taken from paddr above the byte offset.
  localparam logic REG_ITERATION_COUNT = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_CHECK    = 4'd1,
    S_BRANCH   = 4'd2,
    S_DBL_SQ   = 4'd3,
    S_DBL_CU   = 4'd4,
    S_DBL_CMP  = 4'd5,
    S_TO_REF   = 4'd6,
    S_HLV_SQ   = 4'd7,
    S_HLV_CU   = 4'd8,
    S_HLV_CMP  = 4'd9,
    S_REF_TOP  = 4'd10,
    S_REF_SQ   = 4'd11,
    S_REF_CU   = 4'd12,
    S_REF_CMP  = 4'd13,
    S_EMIT     = 4'd14,
    S_EMIT_RAW = 4'd15
  } step_t;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_SQ   = 2'd1,
    MUL_CU   = 2'd2
  } mul_op_t;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_LOAD     = 3'd1,
    OP_DBL      = 3'd2,
    OP_HLV      = 3'd3,
    OP_REF_PREP = 3'd4,
    OP_REF      = 3'd5,
    OP_EMIT     = 3'd6,
    OP_EMIT_RAW = 3'd7
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NO_START  = 3'd2,
    C_TRIVIAL   = 3'd3,
    C_BELOW_ONE = 3'd4,
    C_CUBE_LE   = 3'd5,
    C_CUBE_GE   = 3'd6,
    C_CNT_ZERO  = 3'd7
  } cond_t;

  typedef struct packed {
    mul_op_t mul;
    dp_op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic trivial;
    logic below_one;
    logic cube_le;
    logic cube_ge;
    logic cnt_zero;
  } stat_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t row(mul_op_t mul, dp_op_t op, cond_t cond, step_t target);
    ucode_t w;
    w.ctrl.mul = mul;
    w.ctrl.op  = op;
    w.cond     = cond;
    w.target   = target;
    return w;
  endfunction

  // One control word per step. A step falls through to the next one unless
  // its condition holds, in which case it jumps to its target.
  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    case (pc)
      S_IDLE:     w = row(MUL_NONE, OP_LOAD,     C_NO_START,  S_IDLE);
      S_CHECK:    w = row(MUL_NONE, OP_NONE,     C_TRIVIAL,   S_EMIT_RAW);
      S_BRANCH:   w = row(MUL_NONE, OP_NONE,     C_BELOW_ONE, S_HLV_SQ);
      S_DBL_SQ:   w = row(MUL_SQ,   OP_NONE,     C_NEVER,     S_IDLE);
      S_DBL_CU:   w = row(MUL_CU,   OP_NONE,     C_NEVER,     S_IDLE);
      S_DBL_CMP:  w = row(MUL_NONE, OP_DBL,      C_CUBE_LE,   S_DBL_SQ);
      S_TO_REF:   w = row(MUL_NONE, OP_NONE,     C_ALWAYS,    S_REF_TOP);
      S_HLV_SQ:   w = row(MUL_SQ,   OP_NONE,     C_NEVER,     S_IDLE);
      S_HLV_CU:   w = row(MUL_CU,   OP_NONE,     C_NEVER,     S_IDLE);
      S_HLV_CMP:  w = row(MUL_NONE, OP_HLV,      C_CUBE_GE,   S_HLV_SQ);
      S_REF_TOP:  w = row(MUL_NONE, OP_REF_PREP, C_CNT_ZERO,  S_EMIT);
      S_REF_SQ:   w = row(MUL_SQ,   OP_NONE,     C_NEVER,     S_IDLE);
      S_REF_CU:   w = row(MUL_CU,   OP_NONE,     C_NEVER,     S_IDLE);
      S_REF_CMP:  w = row(MUL_NONE, OP_REF,      C_ALWAYS,    S_REF_TOP);
      S_EMIT:     w = row(MUL_NONE, OP_EMIT,     C_ALWAYS,    S_IDLE);
      S_EMIT_RAW: w = row(MUL_NONE, OP_EMIT_RAW, C_ALWAYS,    S_IDLE);
      default:    w = row(MUL_NONE, OP_NONE,     C_ALWAYS,    S_IDLE);
    endcase
    return w;
  endfunction

endpackage

@@ sv/fixed_point_cube_root_top.sv @@
// Top level of the fixed-point cube root block.
// Instantiates fpcr_cfg, fpcr_seq and fpcr_dp; depends on fpcr_pkg.
//
//   channel   ports                                    beat taken when
//   -------   --------------------------------------   --------------------------------
//   config    psel penable pwrite paddr pwdata         psel & penable & pwrite & pready
//             prdata pready
//   input     start busy in_x_value                    start & !busy
//   result    out_strobe out_root_value                out_strobe (one cycle)
//
// Operands of zero or magnitude one skip the search and come back raw.
// Others run bracket trials, then iteration_count refinement trials, with
// one extra step when the magnitude is above one; each trial runs a
// square, a cube and a compare through the one shared multiplier.
// One operand at a time; busy is high from the cycle after the beat until the
// result is registered, and a new beat may be taken while the result shows.
// Synchronous active-low reset sets iteration_count to 20 and idles the block.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module fixed_point_cube_root_top #(
  parameter int FRAC_BITS  = fpcr_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = fpcr_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpcr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fpcr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fpcr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [DATA_WIDTH-1:0]     in_x_value,
  output logic                             out_strobe,
  output logic signed [DATA_WIDTH-1:0]     out_root_value
);

  logic [fpcr_pkg::ITER_W-1:0] iteration_count;
  fpcr_pkg::ctrl_t             ctrl;
  fpcr_pkg::stat_t             stat;

  fpcr_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .iteration_count (iteration_count)
  );

  fpcr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  fpcr_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .ctrl            (ctrl),
    .iteration_count (iteration_count),
    .in_x_value      (in_x_value),
    .stat            (stat),
    .out_strobe      (out_strobe),
    .out_root_value  (out_root_value)
  );

endmodule

@@ sv/fpcr_cfg.sv @@
// APB-style configuration register for the cube root block.
// Holds the refinement step count; depends on fpcr_pkg.
`timescale 1ns / 1ps

module fpcr_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpcr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fpcr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fpcr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [fpcr_pkg::ITER_W-1:0]      iteration_count
);

  logic                          wr_en;
  logic                          reg_idx;
  logic [fpcr_pkg::ITER_W-1:0]   iter_r;
  logic [fpcr_pkg::ITER_W-1:0]   iter_nxt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[fpcr_pkg::CFG_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    iter_nxt = iter_r;
    if (wr_en && (reg_idx == fpcr_pkg::REG_ITERATION_COUNT)) begin
      iter_nxt = pwdata[fpcr_pkg::ITER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= fpcr_pkg::ITER_RESET;
    end else begin
      iter_r <= iter_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == fpcr_pkg::REG_ITERATION_COUNT) begin
      prdata = fpcr_pkg::CFG_DATA_W'(iter_r);
    end
  end

  assign iteration_count = iter_r;

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
      (wr_en && (reg_idx == fpcr_pkg::REG_ITERATION_COUNT))
      |=> (iter_r == $past(pwdata[fpcr_pkg::ITER_W-1:0])))
    else $error("iteration_count not updated by a register write");

endmodule

@@ sv/fpcr_seq.sv @@
// Microcode sequencer for the cube root block: step counter, table lookup
// and conditional jumps. Depends on fpcr_pkg for the table and types.
`timescale 1ns / 1ps

module fpcr_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  fpcr_pkg::stat_t   stat,
  output fpcr_pkg::ctrl_t   ctrl,
  output logic              busy
);

  fpcr_pkg::step_t   pc_r;
  fpcr_pkg::step_t   pc_nxt;
  fpcr_pkg::ucode_t  uc;
  logic              take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= fpcr_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    uc = fpcr_pkg::ucode_rom(pc_r);
    case (uc.cond)
      fpcr_pkg::C_NEVER:     take = 1'b0;
      fpcr_pkg::C_ALWAYS:    take = 1'b1;
      fpcr_pkg::C_NO_START:  take = !start;
      fpcr_pkg::C_TRIVIAL:   take = stat.trivial;
      fpcr_pkg::C_BELOW_ONE: take = stat.below_one;
      fpcr_pkg::C_CUBE_LE:   take = stat.cube_le;
      fpcr_pkg::C_CUBE_GE:   take = stat.cube_ge;
      fpcr_pkg::C_CNT_ZERO:  take = stat.cnt_zero;
      default:               take = 1'b1;
    endcase
    if (take) begin
      pc_nxt = uc.target;
    end else begin
      pc_nxt = fpcr_pkg::step_t'(pc_r + 4'd1);
    end
    ctrl = uc.ctrl;
    busy = (pc_r != fpcr_pkg::S_IDLE);
  end

  a_seq_accept: assert property (@(posedge clk) disable iff (!rst_n)
      (start && !busy) |=> (pc_r == fpcr_pkg::S_CHECK))
    else $error("accepted beat did not enter the check step");

endmodule

@@ sv/fpcr_dp.sv @@
// Datapath of the cube root block: operand registers, one shared multiplier
// with a registered product, saturating shifts and compares.
// Driven by the control word of fpcr_seq; depends on fpcr_pkg.
`timescale 1ns / 1ps

module fpcr_dp #(
  parameter int FRAC_BITS  = fpcr_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = fpcr_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  fpcr_pkg::ctrl_t               ctrl,
  input  logic [fpcr_pkg::ITER_W-1:0]   iteration_count,
  input  logic signed [DATA_WIDTH-1:0]  in_x_value,
  output fpcr_pkg::stat_t               stat,
  output logic                          out_strobe,
  output logic signed [DATA_WIDTH-1:0]  out_root_value
);

  localparam int DW   = DATA_WIDTH;
  localparam int RW_A = (DW + 2 * FRAC_BITS + 2) / 3 + 1;
  localparam int RW_B = (DW > RW_A) ? DW : RW_A;
  // Root width: holds the largest bracket step and the start value one.
  localparam int RW   = (RW_B > FRAC_BITS + 2) ? RW_B : FRAC_BITS + 2;
  // Cubes saturate at CW bits, squares at SW bits; both stay above any
  // magnitude once saturated, so no compare changes.
  localparam int CW   = DW + 1;
  localparam int SW   = (FRAC_BITS > CW) ? FRAC_BITS : CW;
  localparam int BW   = (SW > RW) ? SW : RW;
  localparam int PW   = BW + RW;
  localparam int EW   = ((DW > FRAC_BITS) ? DW : FRAC_BITS) + 1;

  localparam logic [EW-1:0] ONE_EW = EW'(1) << FRAC_BITS;
  localparam logic [RW-1:0] ONE_RW = RW'(1) << FRAC_BITS;

  logic [DW-1:0]               raw_r;
  logic                        neg_r;
  logic [DW-1:0]               mag_r;
  logic [RW-1:0]               step_r;
  logic [RW-1:0]               trial_r;
  logic [RW-1:0]               y_r;
  logic [PW-1:0]               prod_r;
  logic [fpcr_pkg::ITER_W-1:0] cnt_r;
  logic                        out_strobe_r;
  logic [DW-1:0]               out_root_r;

  logic [DW-1:0]  x_u;
  logic [DW-1:0]  mag_nxt;
  logic [PW-1:0]  prod_sh;
  logic [SW-1:0]  sq_sat;
  logic [CW-1:0]  cube_sat;
  logic [BW-1:0]  mul_b;
  logic [PW-1:0]  prod_nxt;
  logic [EW-1:0]  mag_ext;
  logic [EW-1:0]  cube_ext;
  logic [RW-1:0]  y_signed;

  assign x_u     = in_x_value;
  assign mag_nxt = x_u[DW-1] ? (~x_u + DW'(1)) : x_u;

  assign prod_sh  = prod_r >> FRAC_BITS;
  assign sq_sat   = (|prod_sh[PW-1:SW]) ? {SW{1'b1}} : prod_sh[SW-1:0];
  assign cube_sat = (|prod_sh[PW-1:CW]) ? {CW{1'b1}} : prod_sh[CW-1:0];

  assign mul_b    = (ctrl.mul == fpcr_pkg::MUL_SQ) ? BW'(trial_r) : BW'(sq_sat);
  assign prod_nxt = PW'(trial_r) * PW'(mul_b);

  assign mag_ext  = EW'(mag_r);
  assign cube_ext = EW'(cube_sat);
  assign y_signed = neg_r ? (~y_r + RW'(1)) : y_r;

  always_comb begin
    stat.trivial   = (mag_r == '0) || (mag_ext == ONE_EW);
    stat.below_one = (mag_ext < ONE_EW);
    stat.cube_le   = (cube_ext <= mag_ext);
    stat.cube_ge   = (cube_ext >= mag_ext);
    stat.cnt_zero  = (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (ctrl.op == fpcr_pkg::OP_EMIT) || (ctrl.op == fpcr_pkg::OP_EMIT_RAW);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul != fpcr_pkg::MUL_NONE) begin
      prod_r <= prod_nxt;
    end
    case (ctrl.op)
      fpcr_pkg::OP_LOAD: begin
        if (start) begin
          raw_r   <= x_u;
          neg_r   <= x_u[DW-1];
          mag_r   <= mag_nxt;
          step_r  <= ONE_RW;
          trial_r <= ONE_RW;
          y_r     <= '0;
          cnt_r   <= iteration_count;
        end
      end
      fpcr_pkg::OP_DBL: begin
        if (stat.cube_le) begin
          step_r  <= step_r << 1;
          trial_r <= step_r << 1;
        end else begin
          y_r <= step_r >> 1;
        end
      end
      fpcr_pkg::OP_HLV: begin
        if (stat.cube_ge) begin
          step_r  <= step_r >> 1;
          trial_r <= step_r >> 1;
        end else begin
          y_r <= step_r;
        end
      end
      fpcr_pkg::OP_REF_PREP: begin
        if (!stat.cnt_zero) begin
          step_r  <= step_r >> 1;
          trial_r <= y_r + (step_r >> 1);
          cnt_r   <= cnt_r - fpcr_pkg::ITER_W'(1);
        end
      end
      fpcr_pkg::OP_REF: begin
        if (stat.cube_le) begin
          y_r <= trial_r;
        end
      end
      fpcr_pkg::OP_EMIT: begin
        out_root_r <= y_signed[DW-1:0];
      end
      fpcr_pkg::OP_EMIT_RAW: begin
        // Zero and plus or minus one come back unchanged.
        out_root_r <= raw_r;
      end
      default: begin
      end
    endcase
  end

  assign out_strobe     = out_strobe_r;
  assign out_root_value = out_root_r;

  a_dp_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
      out_strobe_r |=> !out_strobe_r)
    else $error("result strobe high on two cycles in a row");

  a_dp_trial_order: assert property (@(posedge clk) disable iff (!rst_n)
      (ctrl.op == fpcr_pkg::OP_REF) |-> (trial_r >= y_r))
    else $error("trial root below the accepted root");

  a_dp_step_pow2: assert property (@(posedge clk) disable iff (!rst_n)
      (ctrl.mul != fpcr_pkg::MUL_NONE) |-> $onehot0(step_r))
    else $error("step is not a power of two");

endmodule
